@@ rtl/v3n_pkg.sv @@
// Package for vec3_normalize: shared width constants.
// No dependencies.
package v3n_pkg;
    localparam int COMP_WIDTH_DEF = 16;
    localparam int UNIT_WIDTH     = 16;
    localparam int UNIT_FRAC      = 14;
endpackage

@@ rtl/v3n_sqrt_cell.sv @@
// One restoring square root step: one root bit per cell.
// Uses v3n_pkg.
module v3n_sqrt_cell import v3n_pkg::*; #(
    parameter int SW  = 34,
    parameter int RW  = 17,
    parameter int MW  = 16,
    parameter int IDX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic [SW-1:0]        i_rem,
    input  logic [RW-1:0]        i_root,
    input  logic [3*MW+2:0]      i_side,
    output logic                 o_vld,
    output logic [SW-1:0]        o_rem,
    output logic [RW-1:0]        o_root,
    output logic [3*MW+2:0]      o_side
);
    logic [SW+1:0] trial;
    logic [SW+1:0] remx;
    logic          take;
    logic [SW-1:0] n_rem;
    logic [RW-1:0] n_root;
    logic          r_vld;
    logic [SW-1:0] r_rem;
    logic [RW-1:0] r_root;
    logic [3*MW+2:0] r_side;

    always_comb begin
        trial  = (SW+2)'({i_root, 2'b01}) << (2*IDX);
        remx   = (SW+2)'(i_rem);
        take   = remx >= trial;
        n_rem  = take ? SW'(remx - trial) : i_rem;
        n_root = take ? RW'({i_root, 1'b1}) : RW'({i_root, 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_rem  <= n_rem;
        r_root <= n_root;
        r_side <= i_side;
    end

    assign o_vld  = r_vld;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_side = r_side;
endmodule

@@ rtl/v3n_div_cell.sv @@
// One restoring division step for three quotients sharing a divisor.
// Uses v3n_pkg.
module v3n_div_cell import v3n_pkg::*; #(
    parameter int DW = 17,
    parameter int QW = 15,
    parameter int MW = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  logic [DW-1:0]   i_den,
    input  logic [3*DW-1:0] i_rem,
    input  logic [3*MW-1:0] i_num,
    input  logic [3*QW-1:0] i_quo,
    input  logic [2:0]      i_neg,
    output logic            o_vld,
    output logic [DW-1:0]   o_den,
    output logic [3*DW-1:0] o_rem,
    output logic [3*MW-1:0] o_num,
    output logic [3*QW-1:0] o_quo,
    output logic [2:0]      o_neg
);
    logic [3*DW-1:0] n_rem;
    logic [3*QW-1:0] n_quo;
    logic [3*MW-1:0] n_num;
    logic            r_vld;
    logic [DW-1:0]   r_den;
    logic [3*DW-1:0] r_rem;
    logic [3*MW-1:0] r_num;
    logic [3*QW-1:0] r_quo;
    logic [2:0]      r_neg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic [DW:0] sh;
            sh = {i_rem[k*DW +: DW], i_num[k*MW + MW-1]};
            n_num[k*MW +: MW] = {i_num[k*MW +: MW-1], 1'b0};
            if (sh >= {1'b0, i_den}) begin
                n_rem[k*DW +: DW] = DW'(sh - {1'b0, i_den});
                n_quo[k*QW +: QW] = {i_quo[k*QW +: QW-1], 1'b1};
            end else begin
                n_rem[k*DW +: DW] = DW'(sh);
                n_quo[k*QW +: QW] = {i_quo[k*QW +: QW-1], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_den <= i_den;
        r_rem <= n_rem;
        r_num <= n_num;
        r_quo <= n_quo;
        r_neg <= i_neg;
    end

    assign o_vld = r_vld;
    assign o_den = r_den;
    assign o_rem = r_rem;
    assign o_num = r_num;
    assign o_quo = r_quo;
    assign o_neg = r_neg;
endmodule

@@ rtl/vec3_normalize.sv @@
// Top level of vec3_normalize: squares, root chain, divide chain, output.
// Uses v3n_pkg, v3n_sqrt_cell, v3n_div_cell.
//
//  channel | signals                          | handshake
//  --------+----------------------------------+---------------------------
//  input   | i_vec_x, i_vec_y, i_vec_z        | i_start & !o_busy
//  result  | o_length, o_unit_x/y/z, o_zero_* | o_strobe, one cycle
//
// One item per cycle. Registers in order: magnitude, squares, (COMP_WIDTH+1)
// root cells, (COMP_WIDTH+UNIT_FRAC) divide cells and the output; the divide
// chain, one quotient bit per cell, sets the depth. o_busy is always low.
// Synchronous active-low reset clears all valid flags; payload is not reset.
// The receiver cannot stall; results appear once and are gone.
module vec3_normalize import v3n_pkg::*; #(
    parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic signed [COMP_WIDTH-1:0] i_vec_x,
    input  logic signed [COMP_WIDTH-1:0] i_vec_y,
    input  logic signed [COMP_WIDTH-1:0] i_vec_z,
    output logic                         o_strobe,
    output logic [COMP_WIDTH-1:0]        o_length,
    output logic signed [UNIT_WIDTH-1:0] o_unit_x,
    output logic signed [UNIT_WIDTH-1:0] o_unit_y,
    output logic signed [UNIT_WIDTH-1:0] o_unit_z,
    output logic                         o_zero_vector
);
    localparam int MW = COMP_WIDTH;
    localparam int SW = 2*MW + 2;
    localparam int RW = MW + 1;
    localparam int NR = RW;
    localparam int DW = RW;
    localparam int QW = UNIT_FRAC + 1;
    localparam int ND = MW + UNIT_FRAC;
    localparam int NW = MW + UNIT_FRAC;

    logic              r_v0;
    logic [MW-1:0]     r_mag [3];
    logic [2:0]        r_neg0;
    logic [2*MW-1:0]   n_sq [3];
    logic [2*MW-1:0]   r_sq [3];
    logic [2:0]        r_neg1;
    logic [3*MW-1:0]   r_mag1;
    logic              r_v1;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= i_start;
            r_v1 <= r_v0;
        end
        r_neg0 <= {i_vec_z[MW-1], i_vec_y[MW-1], i_vec_x[MW-1]};
        r_mag[0] <= i_vec_x[MW-1] ? MW'(-i_vec_x) : MW'(i_vec_x);
        r_mag[1] <= i_vec_y[MW-1] ? MW'(-i_vec_y) : MW'(i_vec_y);
        r_mag[2] <= i_vec_z[MW-1] ? MW'(-i_vec_z) : MW'(i_vec_z);
        for (int k = 0; k < 3; k++) r_sq[k] <= n_sq[k];
        r_neg1 <= r_neg0;
        r_mag1 <= {r_mag[2], r_mag[1], r_mag[0]};
    end

    always_comb begin
        for (int k = 0; k < 3; k++) n_sq[k] = r_mag[k] * r_mag[k];
    end

    logic [SW-1:0]   s_rem  [NR+1];
    logic [RW-1:0]   s_root [NR+1];
    logic [3*MW+2:0] s_side [NR+1];
    logic            s_vld  [NR+1];

    assign s_rem[0]  = SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
    assign s_root[0] = '0;
    assign s_side[0] = {r_neg1, r_mag1};
    assign s_vld[0]  = r_v1;

    for (genvar g = 0; g < NR; g++) begin : g_sqrt
        v3n_sqrt_cell #(.SW(SW), .RW(RW), .MW(MW), .IDX(NR-1-g)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_vld(s_vld[g]), .i_rem(s_rem[g]), .i_root(s_root[g]),
            .i_side(s_side[g]),
            .o_vld(s_vld[g+1]), .o_rem(s_rem[g+1]), .o_root(s_root[g+1]),
            .o_side(s_side[g+1])
        );
    end

    logic            d_vld [ND+1];
    logic [DW-1:0]   d_den [ND+1];
    logic [3*DW-1:0] d_rem [ND+1];
    logic [3*NW-1:0] d_num [ND+1];
    logic [3*QW-1:0] d_quo [ND+1];
    logic [2:0]      d_neg [ND+1];

    assign d_vld[0] = s_vld[NR];
    assign d_den[0] = s_root[NR];
    assign d_rem[0] = '0;
    assign d_quo[0] = '0;
    assign d_neg[0] = s_side[NR][3*MW +: 3];
    for (genvar k = 0; k < 3; k++) begin : g_num
        assign d_num[0][k*NW +: NW] = {s_side[NR][k*MW +: MW], UNIT_FRAC'(0)};
    end

    for (genvar g = 0; g < ND; g++) begin : g_div
        v3n_div_cell #(.DW(DW), .QW(QW), .MW(NW)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_vld(d_vld[g]), .i_den(d_den[g]), .i_rem(d_rem[g]),
            .i_num(d_num[g]), .i_quo(d_quo[g]), .i_neg(d_neg[g]),
            .o_vld(d_vld[g+1]), .o_den(d_den[g+1]), .o_rem(d_rem[g+1]),
            .o_num(d_num[g+1]), .o_quo(d_quo[g+1]), .o_neg(d_neg[g+1])
        );
    end

    logic                  r_strobe;
    logic [MW-1:0]         r_length;
    logic [UNIT_WIDTH-1:0] r_unit [3];
    logic                  r_zero;
    logic                  zero;

    assign zero = d_den[ND] == '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= d_vld[ND];
        end
        r_length <= MW'(d_den[ND]);
        r_zero   <= zero;
        for (int k = 0; k < 3; k++) begin
            logic [UNIT_WIDTH-1:0] q;
            q = zero ? '0 : UNIT_WIDTH'(d_quo[ND][k*QW +: QW]);
            r_unit[k] <= d_neg[ND][k] ? UNIT_WIDTH'(-q) : q;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_length      = r_length;
    assign o_unit_x      = r_unit[0];
    assign o_unit_y      = r_unit[1];
    assign o_unit_z      = r_unit[2];
    assign o_zero_vector = r_zero;
endmodule

@@ rtl/v3n_checker.sv @@
// Port checker for vec3_normalize, bound to the top level.
// Uses v3n_pkg.
module v3n_checker import v3n_pkg::*; #(
    parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_busy,
    input logic                         o_strobe,
    input logic [COMP_WIDTH-1:0]        o_length,
    input logic signed [UNIT_WIDTH-1:0] o_unit_x,
    input logic                         o_zero_vector
);
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_zero_vector == (o_length == '0))) else $error("zero flag");
    a_zero_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_zero_vector |-> o_unit_x == '0) else $error("zero unit");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_unit_x <= 16384 && o_unit_x >= -16384)) else $error("range");
    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy) else $error("busy");
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe) else $error("strobe after reset");
endmodule

bind vec3_normalize v3n_checker #(.COMP_WIDTH(COMP_WIDTH)) u_v3n_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_busy(o_busy), .o_strobe(o_strobe),
    .o_length(o_length), .o_unit_x(o_unit_x), .o_zero_vector(o_zero_vector)
);
